// ===== hw/rtl/dimmer_level_frame_builder_assert.svh =====
// ----------------------------------------------------------------------------
// Dimmer level frame builder assertion macros
// Shorthand for clocked assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef DIMMER_LEVEL_FRAME_BUILDER_ASSERT_SVH
`define DIMMER_LEVEL_FRAME_BUILDER_ASSERT_SVH

// The antecedent implies the consequent in the same cycle.
`define DLFB_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("dlfb assertion failed");

// The antecedent implies the consequent in the following cycle.
`define DLFB_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("dlfb assertion failed");

`endif

// ===== hw/rtl/dlfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Dimmer level frame builder package
// Shared types and constants of the frame builder.
// ----------------------------------------------------------------------------
package dlfb_pkg;

  localparam int unsigned LEVEL_W      = 17;
  localparam int unsigned WORD_W       = 16;
  localparam int unsigned SETUP_W      = 48;
  localparam int unsigned CHAN_W       = 4;
  localparam int unsigned RESP_W       = 4;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned QPTR_W       = 1;
  localparam int unsigned QCNT_W       = 2;

  localparam logic [RESP_W-1:0] LAST_RESPONDER = 4'd11;
  localparam logic [7:0]        HEADER_BASE    = 8'h40;
  localparam logic [WORD_W-1:0] FULL_SCALE_RST = 16'd36000;

  localparam logic [CFG_IDX_W-1:0] REG_FULL_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SETUP_HIGH = 2'd2;

  typedef enum logic [2:0] {
    SEL_HDR_LO,
    SEL_HDR_HI,
    SEL_WORD_LO,
    SEL_WORD_HI,
    SEL_CHK_LO,
    SEL_CHK_HI
  } byte_sel_e;

  typedef struct packed {
    logic              first;
    logic              last;
    logic [WORD_W-1:0] hdr;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] chk;
  } entry_t;

endpackage

// ===== hw/rtl/dlfb_front.sv =====
// ----------------------------------------------------------------------------
// Dimmer level frame builder front end
// Holds the registers, scales each level and tracks frame position and checksum.
// ----------------------------------------------------------------------------
module dlfb_front #(
  parameter int unsigned CHANNELS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid,
  input  logic [dlfb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dlfb_pkg::SETUP_W-1:0]    cfg_data_i,
  input  logic                            accept_i,
  input  logic [dlfb_pkg::LEVEL_W-1:0]    level_i,
  output dlfb_pkg::entry_t                entry_o
);

  localparam int unsigned FRAME_CH = (CHANNELS < 2) ? 2 : ((CHANNELS > 12) ? 12 : CHANNELS);
  localparam logic [dlfb_pkg::CHAN_W-1:0] LAST_CHAN = dlfb_pkg::CHAN_W'(FRAME_CH - 1);

  logic [dlfb_pkg::WORD_W-1:0]  full_scale_q, full_scale_d;
  logic [dlfb_pkg::SETUP_W-1:0] setup_low_q, setup_low_d;
  logic [dlfb_pkg::SETUP_W-1:0] setup_high_q, setup_high_d;
  logic [dlfb_pkg::RESP_W-1:0]  responder_q, responder_d;
  logic [dlfb_pkg::CHAN_W-1:0]  chan_q, chan_d;
  logic [dlfb_pkg::WORD_W-1:0]  xor_q, xor_d;

  logic [dlfb_pkg::LEVEL_W+dlfb_pkg::WORD_W-1:0] product;
  logic [dlfb_pkg::LEVEL_W-1:0] scaled;
  logic [dlfb_pkg::WORD_W-1:0]  word;
  logic [2*dlfb_pkg::SETUP_W-1:0] setup_all;
  logic [dlfb_pkg::RESP_W-1:0]  resp_next;
  logic [7:0]                   setup_byte;
  logic [dlfb_pkg::WORD_W-1:0]  hdr;
  logic [dlfb_pkg::WORD_W-1:0]  chk;
  logic                         first;
  logic                         last;

  always_comb begin
    full_scale_d = full_scale_q;
    setup_low_d  = setup_low_q;
    setup_high_d = setup_high_q;
    if (cfg_valid) begin
      case (cfg_index_i)
        dlfb_pkg::REG_FULL_SCALE: full_scale_d = cfg_data_i[dlfb_pkg::WORD_W-1:0];
        dlfb_pkg::REG_SETUP_LOW:  setup_low_d  = cfg_data_i;
        dlfb_pkg::REG_SETUP_HIGH: setup_high_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  assign product = level_i * full_scale_q;
  assign scaled  = product[dlfb_pkg::LEVEL_W+dlfb_pkg::WORD_W-1:dlfb_pkg::WORD_W];
  assign word    = scaled[dlfb_pkg::LEVEL_W-1] ? '1 : scaled[dlfb_pkg::WORD_W-1:0];

  assign first     = (chan_q == '0);
  assign last      = (chan_q == LAST_CHAN);
  assign resp_next = (responder_q == dlfb_pkg::LAST_RESPONDER) ? '0 : responder_q + 1'b1;
  assign setup_all = {setup_high_q, setup_low_q};
  assign setup_byte = setup_all[{resp_next, 3'b000} +: 8];
  assign hdr       = {setup_byte, dlfb_pkg::HEADER_BASE + 8'(resp_next)};
  assign chk       = (first ? hdr : xor_q) ^ word;

  always_comb begin
    responder_d = responder_q;
    chan_d      = chan_q;
    xor_d       = xor_q;
    if (accept_i) begin
      responder_d = first ? resp_next : responder_q;
      chan_d      = last ? '0 : chan_q + 1'b1;
      xor_d       = chk;
    end
  end

  assign entry_o.first = first;
  assign entry_o.last  = last;
  assign entry_o.hdr   = hdr;
  assign entry_o.word  = word;
  assign entry_o.chk   = chk;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_scale_q <= dlfb_pkg::FULL_SCALE_RST;
      setup_low_q  <= '0;
      setup_high_q <= '0;
      responder_q  <= '0;
      chan_q       <= '0;
      xor_q        <= '0;
    end else begin
      full_scale_q <= full_scale_d;
      setup_low_q  <= setup_low_d;
      setup_high_q <= setup_high_d;
      responder_q  <= responder_d;
      chan_q       <= chan_d;
      xor_q        <= xor_d;
    end
  end

endmodule

// ===== hw/rtl/dlfb_queue.sv =====
// ----------------------------------------------------------------------------
// Dimmer level frame builder entry queue
// A short queue of frame entries between the front end and the serializer.
// ----------------------------------------------------------------------------
module dlfb_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  dlfb_pkg::entry_t wr_entry_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             valid_o,
  output dlfb_pkg::entry_t rd_entry_o
);

  dlfb_pkg::entry_t mem_q [dlfb_pkg::QUEUE_DEPTH];

  logic [dlfb_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [dlfb_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [dlfb_pkg::QCNT_W-1:0] count_q, count_d;

  assign full_o     = (count_q == dlfb_pkg::QCNT_W'(dlfb_pkg::QUEUE_DEPTH));
  assign valid_o    = (count_q != '0);
  assign rd_entry_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = rd_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (wr_i && !rd_i) begin
      count_d = count_q + 1'b1;
    end else if (rd_i && !wr_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      mem_q[wr_ptr_q] <= wr_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

// ===== hw/rtl/dlfb_back.sv =====
// ----------------------------------------------------------------------------
// Dimmer level frame builder serializer
// Walks the bytes of the head entry into the result register, low byte first.
// ----------------------------------------------------------------------------
module dlfb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  dlfb_pkg::entry_t head_i,
  output logic             deq_o,
  output logic             empty,
  input  logic             pop,
  output logic [7:0]       tx_byte_o,
  output logic             frame_last_o
);

  logic [1:0]          step_q, step_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          byte_q, byte_d;
  logic                last_q, last_d;
  dlfb_pkg::byte_sel_e sel;
  dlfb_pkg::byte_sel_e end_sel;
  logic                load;
  logic                done;
  logic [7:0]          sel_byte;

  assign sel     = dlfb_pkg::byte_sel_e'(3'(step_q) + (head_i.first ? 3'd0 : 3'd2));
  assign end_sel = head_i.last ? dlfb_pkg::SEL_CHK_HI : dlfb_pkg::SEL_WORD_HI;
  assign done    = (sel == end_sel);
  assign load    = head_valid_i && (!out_valid_q || pop);
  assign deq_o   = load && done;

  always_comb begin
    case (sel)
      dlfb_pkg::SEL_HDR_LO:  sel_byte = head_i.hdr[7:0];
      dlfb_pkg::SEL_HDR_HI:  sel_byte = head_i.hdr[15:8];
      dlfb_pkg::SEL_WORD_LO: sel_byte = head_i.word[7:0];
      dlfb_pkg::SEL_WORD_HI: sel_byte = head_i.word[15:8];
      dlfb_pkg::SEL_CHK_LO:  sel_byte = head_i.chk[7:0];
      dlfb_pkg::SEL_CHK_HI:  sel_byte = head_i.chk[15:8];
      default:               sel_byte = '0;
    endcase
  end

  always_comb begin
    step_d      = step_q;
    byte_d      = byte_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !pop;
    if (load) begin
      step_d      = done ? 2'd0 : step_q + 2'd1;
      byte_d      = sel_byte;
      last_d      = (sel == dlfb_pkg::SEL_CHK_HI);
      out_valid_d = 1'b1;
    end
  end

  assign empty        = !out_valid_q;
  assign tx_byte_o    = byte_q;
  assign frame_last_o = last_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/dimmer_level_frame_builder.sv =====
// The first byte of an item goes from the entry queue into the result register and
// reaches the result ports once the result register is free.
// The result register gives one byte per cycle as long as pop is asserted; an item is
// two bytes, or four on the first and last channel of a frame.
// Reset clears frame position, responder and checksum and loads the register defaults.
// ----------------------------------------------------------------------------
// Dimmer level frame builder
// Turns channel levels into the bytes of dimmer command frames.
// ----------------------------------------------------------------------------
module dimmer_level_frame_builder #(
  parameter int unsigned CHANNELS = 12
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dlfb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [dlfb_pkg::SETUP_W-1:0]    cfg_data_i,
  input  logic                            push,
  output logic                            full,
  input  logic [dlfb_pkg::LEVEL_W-1:0]    level_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [7:0]                      tx_byte_o,
  output logic                            frame_last_o
);

  dlfb_pkg::entry_t front_entry;
  dlfb_pkg::entry_t head_entry;
  logic             accept;
  logic             head_valid;
  logic             deq;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  dlfb_front #(
    .CHANNELS(CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid  (cfg_valid),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .level_i    (level_i),
    .entry_o    (front_entry)
  );

  dlfb_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept),
    .wr_entry_i(front_entry),
    .full_o    (full),
    .rd_i      (deq),
    .valid_o   (head_valid),
    .rd_entry_o(head_entry)
  );

  dlfb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_valid_i(head_valid),
    .head_i      (head_entry),
    .deq_o       (deq),
    .empty       (empty),
    .pop         (pop),
    .tx_byte_o   (tx_byte_o),
    .frame_last_o(frame_last_o)
  );

endmodule

// ===== hw/rtl/dlfb_checker.sv =====
// ----------------------------------------------------------------------------
// Dimmer level frame builder checker
// Watches the queue-style ports of the frame builder over time.
// ----------------------------------------------------------------------------
`include "dimmer_level_frame_builder_assert.svh"

module dlfb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] tx_byte_o,
  input logic       frame_last_o
);

  `DLFB_ASSERT_NEXT(a_word_holds, !empty && !pop, !empty)
  `DLFB_ASSERT_NEXT(a_word_stable, !empty && !pop, $stable(tx_byte_o) && $stable(frame_last_o))
  `DLFB_ASSERT_IMP(a_full_after_push, $rose(full), $past(push))
  `DLFB_ASSERT_IMP(a_full_has_result, full, !empty)

endmodule

bind dimmer_level_frame_builder dlfb_checker u_checker (.*);

// ===== tb/dimmer_level_frame_builder_tb.sv =====
// ----------------------------------------------------------------------------
// Dimmer level frame builder testbench
// Sends channel levels through the push side and pops frame bytes from the
// result side. Every byte is compared with a frame predictor kept in the
// testbench: a short table of directed rows comes first, then random phases
// with different register settings, random idling on both sides and one
// long stall of the result side.
// ----------------------------------------------------------------------------
module dimmer_level_frame_builder_tb;

  localparam int unsigned FRAME_CHANNELS = 12;
  localparam int unsigned CYCLE_LIMIT    = 200000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned PHASES         = 6;
  localparam int unsigned PHASE_ITEMS    = 70;
  localparam logic [dlfb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam logic [dlfb_pkg::LEVEL_W-1:0]   LEVEL_FULL = 17'h10000;
  localparam logic [dlfb_pkg::LEVEL_W-1:0]   LEVEL_MAX  = 17'h1FFFF;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_last;
  } frame_byte_t;

  typedef struct packed {
    logic                           is_reg;
    logic [dlfb_pkg::CFG_IDX_W-1:0] reg_idx;
    logic [dlfb_pkg::SETUP_W-1:0]   reg_data;
    logic [dlfb_pkg::LEVEL_W-1:0]   level;
    logic                           has_word;
    logic [dlfb_pkg::WORD_W-1:0]    word;
  } stim_row_t;

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [dlfb_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [dlfb_pkg::SETUP_W-1:0]   cfg_data_i;
  logic                           push;
  logic                           full;
  logic [dlfb_pkg::LEVEL_W-1:0]   level_i;
  logic                           empty;
  logic                           pop;
  logic [7:0]                     tx_byte_o;
  logic                           frame_last_o;

  logic [dlfb_pkg::WORD_W-1:0]  full_scale_r;
  logic [dlfb_pkg::SETUP_W-1:0] setup_lo_r;
  logic [dlfb_pkg::SETUP_W-1:0] setup_hi_r;
  logic [dlfb_pkg::RESP_W-1:0]  responder_r;
  logic [dlfb_pkg::CHAN_W-1:0]  chan_r;
  logic [dlfb_pkg::WORD_W-1:0]  xor_r;

  frame_byte_t frame_bytes_q[$];
  int unsigned mismatches;
  int unsigned cycle_cnt;
  int unsigned hold_off_req;
  bit          idle_on;

  stim_row_t directed_rows [20] = '{
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              17'd0,      1'b1, 16'h0000},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              LEVEL_FULL, 1'b1, 16'd36000},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              LEVEL_MAX,  1'b1, 16'hFFFF},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              17'd1,      1'b1, 16'h0000},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              17'd65535,  1'b0, 16'h0000},
    '{1'b1, dlfb_pkg::REG_FULL_SCALE, 48'hABCD_0000_FFFF, 17'd0,      1'b0, 16'h0000},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              LEVEL_FULL, 1'b1, 16'hFFFF},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              LEVEL_MAX,  1'b1, 16'hFFFF},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              17'd32768,  1'b1, 16'h7FFF},
    '{1'b1, dlfb_pkg::REG_FULL_SCALE, 48'hFFFF_FFFF_0000, 17'd0,      1'b0, 16'h0000},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              LEVEL_MAX,  1'b1, 16'h0000},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              LEVEL_FULL, 1'b1, 16'h0000},
    '{1'b1, dlfb_pkg::REG_SETUP_LOW,  48'hFFFF_FFFF_FFFF, 17'd0,      1'b0, 16'h0000},
    '{1'b1, dlfb_pkg::REG_SETUP_HIGH, 48'h5AA5_C33C_9669, 17'd0,      1'b0, 16'h0000},
    '{1'b1, REG_UNUSED,               48'hFFFF_FFFF_FFFF, 17'd0,      1'b0, 16'h0000},
    '{1'b1, dlfb_pkg::REG_FULL_SCALE, 48'h0000_0000_8CA0, 17'd0,      1'b0, 16'h0000},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              LEVEL_FULL, 1'b1, 16'd36000},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              17'd98304,  1'b0, 16'h0000},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              17'd21845,  1'b0, 16'h0000},
    '{1'b0, dlfb_pkg::REG_FULL_SCALE, 48'h0,              17'd0,      1'b1, 16'h0000}
  };

  dimmer_level_frame_builder u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push         (push),
    .full         (full),
    .level_i      (level_i),
    .empty        (empty),
    .pop          (pop),
    .tx_byte_o    (tx_byte_o),
    .frame_last_o (frame_last_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic logic [dlfb_pkg::WORD_W-1:0] scale_level(
    input logic [dlfb_pkg::LEVEL_W-1:0] lvl
  );
    logic [32:0] prod;
    prod = {16'b0, lvl} * {17'b0, full_scale_r};
    if (prod[32:16] > 17'h0FFFF) begin
      return 16'hFFFF;
    end
    return prod[31:16];
  endfunction

  function automatic logic [7:0] setup_byte(input logic [dlfb_pkg::RESP_W-1:0] resp);
    if (resp < 6) begin
      return setup_lo_r[8*resp +: 8];
    end
    return setup_hi_r[8*(resp-6) +: 8];
  endfunction

  task automatic queue_word(input logic [dlfb_pkg::WORD_W-1:0] word, input logic last);
    frame_bytes_q.push_back('{tx_byte: word[7:0], frame_last: 1'b0});
    frame_bytes_q.push_back('{tx_byte: word[15:8], frame_last: last});
  endtask

  task automatic predict_frame_bytes(input logic [dlfb_pkg::WORD_W-1:0] word);
    logic [dlfb_pkg::WORD_W-1:0] hdr;
    if (chan_r == 0) begin
      responder_r = (responder_r == dlfb_pkg::LAST_RESPONDER) ? '0 : responder_r + 1'b1;
      hdr = {setup_byte(responder_r), {4'b0, responder_r} + dlfb_pkg::HEADER_BASE};
      xor_r = hdr;
      queue_word(hdr, 1'b0);
    end
    xor_r = xor_r ^ word;
    queue_word(word, 1'b0);
    chan_r = chan_r + 1'b1;
    if (chan_r == FRAME_CHANNELS) begin
      queue_word(xor_r, 1'b1);
      chan_r = '0;
    end
  endtask

  function automatic logic [dlfb_pkg::LEVEL_W-1:0] rand_level();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) begin
      case ($urandom_range(3))
        0: return 17'd0;
        1: return LEVEL_FULL;
        2: return LEVEL_MAX;
        default: return 17'd1;
      endcase
    end
    if (pick < 25) begin
      return dlfb_pkg::LEVEL_W'($urandom_range(131071, 65537));
    end
    return dlfb_pkg::LEVEL_W'($urandom_range(65536, 0));
  endfunction

  function automatic logic [dlfb_pkg::SETUP_W-1:0] rand_setup();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[dlfb_pkg::SETUP_W-1:0];
  endfunction

  task automatic send_level(input logic [dlfb_pkg::LEVEL_W-1:0] lvl, input logic use_word,
                            input logic [dlfb_pkg::WORD_W-1:0] fixed_word);
    while (idle_on && $urandom_range(99) < 22) begin
      push <= 1'b0;
      @(negedge clk_i);
    end
    push    <= 1'b1;
    level_i <= lvl;
    do @(posedge clk_i); while (full);
    predict_frame_bytes(use_word ? fixed_word : scale_level(lvl));
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [dlfb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [dlfb_pkg::SETUP_W-1:0] data);
    push <= 1'b0;
    while (frame_bytes_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_valid   <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      dlfb_pkg::REG_FULL_SCALE: full_scale_r = data[dlfb_pkg::WORD_W-1:0];
      dlfb_pkg::REG_SETUP_LOW:  setup_lo_r   = data;
      dlfb_pkg::REG_SETUP_HIGH: setup_hi_r   = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int unsigned holds_seen;
    int unsigned stall_left;
    holds_seen = 0;
    stall_left = 0;
    pop = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (holds_seen != hold_off_req) begin
        holds_seen = hold_off_req;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_on && $urandom_range(99) < 22) begin
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    frame_byte_t exp_byte;
    if (rst_ni && pop && !empty) begin
      if (frame_bytes_q.size() == 0) begin
        $error("tx_byte: no byte expected, actual %02h", tx_byte_o);
        mismatches++;
      end else begin
        exp_byte = frame_bytes_q.pop_front();
        if (tx_byte_o !== exp_byte.tx_byte) begin
          $error("tx_byte: expected %02h, actual %02h", exp_byte.tx_byte, tx_byte_o);
          mismatches++;
        end
        if (frame_last_o !== exp_byte.frame_last) begin
          $error("frame_last: expected %0d, actual %0d", exp_byte.frame_last, frame_last_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("dimmer_level_frame_builder_tb NOT OK");
    $finish;
  end

  initial begin
    logic [dlfb_pkg::SETUP_W-1:0] fs_data;
    rst_ni       = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index_i  = dlfb_pkg::REG_FULL_SCALE;
    cfg_data_i   = '0;
    push         = 1'b0;
    level_i      = '0;
    mismatches   = 0;
    hold_off_req = 0;
    idle_on      = 1'b1;
    full_scale_r = dlfb_pkg::FULL_SCALE_RST;
    setup_lo_r   = '0;
    setup_hi_r   = '0;
    responder_r  = '0;
    chan_r       = '0;
    xor_r        = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_reg) begin
        write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_data);
      end else begin
        send_level(directed_rows[i].level, directed_rows[i].has_word, directed_rows[i].word);
      end
    end

    // Each phase runs with its own register setting; phase two has no idling and
    // phase three stalls the result side long enough to fill the block.
    for (int unsigned phase = 0; phase < PHASES; phase++) begin
      fs_data = rand_setup();
      case (phase)
        0: fs_data[dlfb_pkg::WORD_W-1:0] = 16'd0;
        1: fs_data[dlfb_pkg::WORD_W-1:0] = 16'hFFFF;
        2: fs_data[dlfb_pkg::WORD_W-1:0] = dlfb_pkg::FULL_SCALE_RST;
        4: fs_data[dlfb_pkg::WORD_W-1:0] = 16'd1;
        default: ;
      endcase
      write_reg(dlfb_pkg::REG_FULL_SCALE, fs_data);
      write_reg(dlfb_pkg::REG_SETUP_LOW,
                (phase == 0) ? '0 : (phase == 1) ? '1 : rand_setup());
      write_reg(dlfb_pkg::REG_SETUP_HIGH,
                (phase == 0) ? '0 : (phase == 1) ? '1 : rand_setup());
      if (phase == 5) begin
        write_reg(REG_UNUSED, rand_setup());
      end
      idle_on = (phase != 2);
      if (phase == 3) begin
        hold_off_req++;
      end
      repeat (PHASE_ITEMS) send_level(rand_level(), 1'b0, '0);
    end

    push <= 1'b0;
    while (frame_bytes_q.size() != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("dimmer_level_frame_builder_tb OK");
    end else begin
      $display("dimmer_level_frame_builder_tb NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/dlfb_pkg.sv
hw/rtl/dlfb_front.sv
hw/rtl/dlfb_queue.sv
hw/rtl/dlfb_back.sv
hw/rtl/dimmer_level_frame_builder.sv
hw/rtl/dlfb_checker.sv
tb/dimmer_level_frame_builder_tb.sv
